// ----- design/tfp_pkg.sv -----
// Shared constants and types of the telemetry frame parser.
`default_nettype none
package tfp_pkg;

  localparam logic [7:0] ChStart = 8'h24;  // '$'
  localparam logic [7:0] ChDrop  = 8'h3F;  // '?'
  localparam logic [7:0] ChEnd   = 8'h21;  // '!'
  localparam logic [7:0] ChSep   = 8'h2D;  // '-'
  localparam logic [7:0] ChNib   = 8'h61;  // 'a'
  localparam logic [7:0] ChDig   = 8'h30;  // '0'

  typedef enum logic [1:0] {
    KIND_ANALOG   = 2'd0,
    KIND_DIGITAL  = 2'd1,
    KIND_COMPLETE = 2'd2
  } kind_e;

  typedef struct packed {
    logic        valid;
    kind_e       kind;
    logic [15:0] value;
    logic [7:0]  slot;
    logic [7:0]  analog_count;
    logic [7:0]  digital_count;
  } result_t;

  function automatic logic [7:0] sat_inc8(input logic [7:0] v);
    sat_inc8 = (v == 8'hFF) ? 8'hFF : v + 8'd1;
  endfunction

endpackage
`default_nettype wire

// ----- design/tfp_decoder.sv -----
// Frame state and per-byte decode of the telemetry frame parser.
`default_nettype none
module tfp_decoder (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             step_i,
  input  wire logic [7:0]       byte_i,
  output tfp_pkg::result_t      res_o
);
  import tfp_pkg::*;

  logic        in_frame_q, in_frame_d;
  logic [7:0]  pos_q, pos_d;
  logic [3:0]  a_total_q, a_total_d;
  logic [3:0]  d_total_q, d_total_d;
  logic [7:0]  d_start_q, d_start_d;
  logic [7:0]  len_q, len_d;
  logic [1:0]  a_nib_q, a_nib_d;
  logic [2:0]  d_nib_q, d_nib_d;
  logic [11:0] a_acc_q, a_acc_d;
  logic [15:0] d_acc_q, d_acc_d;
  logic [7:0]  a_seen_q, a_seen_d;
  logic [7:0]  d_seen_q, d_seen_d;

  logic [7:0]  nib_b, dig_b;
  logic [3:0]  nib, dig;
  logic [11:0] a_add;
  logic [15:0] d_add;

  assign nib_b = byte_i - ChNib;
  assign dig_b = byte_i - ChDig;
  assign nib   = nib_b[3:0];
  assign dig   = dig_b[3:0];
  assign a_add = 12'(nib) << {a_nib_q, 2'b00};
  assign d_add = 16'(nib) << {d_nib_q[1:0], 2'b00};

  always_comb begin
    in_frame_d = in_frame_q;
    pos_d      = pos_q;
    a_total_d  = a_total_q;
    d_total_d  = d_total_q;
    d_start_d  = d_start_q;
    len_d      = len_q;
    a_nib_d    = a_nib_q;
    d_nib_d    = d_nib_q;
    a_acc_d    = a_acc_q;
    d_acc_d    = d_acc_q;
    a_seen_d   = a_seen_q;
    d_seen_d   = d_seen_q;
    res_o      = '{valid: 1'b0, kind: KIND_ANALOG, value: '0, slot: '0,
                   analog_count: a_seen_q, digital_count: d_seen_q};

    if (byte_i == ChStart) begin
      a_seen_d   = '0;
      d_seen_d   = '0;
      a_nib_d    = '0;
      d_nib_d    = '0;
      pos_d      = 8'd1;
      in_frame_d = 1'b1;
    end else begin
      if (byte_i == ChDrop) begin
        in_frame_d = 1'b0;
      end
      if (in_frame_q && byte_i != ChDrop) begin
        if (byte_i == ChEnd && pos_q == len_q) begin
          res_o.valid = 1'b1;
          res_o.kind  = KIND_COMPLETE;
        end else if (pos_q == 8'd1) begin
          a_total_d = dig;
          pos_d     = 8'd2;
        end else if (pos_q == 8'd2) begin
          d_total_d = dig;
          pos_d     = 8'd3;
          d_start_d = {2'b00, a_total_q, 2'b00} + 8'd3;
          len_d     = {2'b00, a_total_q, 2'b00} + {2'b00, dig, 2'b00} + {4'd0, dig} + 8'd3;
        end else if (pos_q < d_start_q) begin
          pos_d = sat_inc8(pos_q);
          if (byte_i == ChSep) begin
            a_nib_d = '0;
            a_acc_d = '0;
          end else if (a_nib_q != 2'd3) begin
            a_acc_d = a_acc_q + a_add;
            if (a_nib_q == 2'd2) begin
              a_seen_d           = sat_inc8(a_seen_q);
              a_nib_d            = 2'd3;
              res_o.valid        = 1'b1;
              res_o.kind         = KIND_ANALOG;
              res_o.value        = {4'd0, a_acc_d};
              res_o.slot         = a_seen_q;
              res_o.analog_count = a_seen_d;
            end else begin
              a_nib_d = a_nib_q + 2'd1;
            end
          end
        end else begin
          pos_d = sat_inc8(pos_q);
          if (byte_i == ChSep) begin
            d_nib_d = '0;
            d_acc_d = '0;
          end else if (d_nib_q < 3'd4) begin
            d_acc_d = d_acc_q + d_add;
            if (d_nib_q == 3'd3) begin
              d_seen_d            = sat_inc8(d_seen_q);
              d_nib_d             = 3'd4;
              res_o.valid         = 1'b1;
              res_o.kind          = KIND_DIGITAL;
              res_o.value         = d_acc_d;
              res_o.slot          = d_seen_q;
              res_o.digital_count = d_seen_d;
            end else begin
              d_nib_d = d_nib_q + 3'd1;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q <= 1'b0;
      pos_q      <= '0;
      a_total_q  <= '0;
      d_total_q  <= '0;
      d_start_q  <= '0;
      len_q      <= '0;
      a_nib_q    <= '0;
      d_nib_q    <= '0;
      a_acc_q    <= '0;
      d_acc_q    <= '0;
      a_seen_q   <= '0;
      d_seen_q   <= '0;
    end else if (step_i) begin
      in_frame_q <= in_frame_d;
      pos_q      <= pos_d;
      a_total_q  <= a_total_d;
      d_total_q  <= d_total_d;
      d_start_q  <= d_start_d;
      len_q      <= len_d;
      a_nib_q    <= a_nib_d;
      d_nib_q    <= d_nib_d;
      a_acc_q    <= a_acc_d;
      d_acc_q    <= d_acc_d;
      a_seen_q   <= a_seen_d;
      d_seen_q   <= d_seen_d;
    end
  end

`ifndef NO_ASSERTIONS
  // The digital nibble counter saturates at four.
  assert property (@(posedge clk_i) disable iff (!rst_ni) d_nib_q <= 3'd4)
    else $error("digital nibble counter out of range");

  // An analog value closes its slot: further nibbles are ignored.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && res_o.valid && res_o.kind == KIND_ANALOG |=> a_nib_q == 2'd3)
    else $error("analog slot not closed after value");

  // A frame-complete report leaves the frame position unchanged.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_i && res_o.valid && res_o.kind == KIND_COMPLETE |=> $stable(pos_q) && in_frame_q)
    else $error("frame state changed by completion");

  // Results are only produced inside a frame.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid |-> in_frame_q)
    else $error("result outside a frame");
`endif

endmodule
`default_nettype wire

// ----- design/telemetry_frame_parser_core.sv -----
// Top level of the telemetry frame parser: input stage, decoder and result register.
// A byte is held in the input stage, decoded, and its result is registered in the result register before it is offered.
// Throughput: one byte per cycle, sustained while results are taken.
// A held result stalls only a waiting byte that gives a result; other bytes still pass.
// Reset (rst_ni low, asynchronous) leaves the parser outside a frame with decoder state and valid flags zero.
`default_nettype none
module telemetry_frame_parser_core (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  in_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [1:0]       kind_o,
  output logic [15:0]      value_o,
  output logic [7:0]       slot_o,
  output logic [7:0]       analog_count_o,
  output logic [7:0]       digital_count_o
);
  import tfp_pkg::*;

  logic             s1_valid_q, s1_valid_d;
  logic [7:0]       s1_byte_q;
  logic             out_valid_q, out_valid_d;
  result_t          out_q;
  result_t          res;
  logic             out_free;
  logic             step;

  // A byte that gives no result may be consumed even while the output is held.
  assign out_free   = !out_valid_q || out_ready_i;
  assign step       = s1_valid_q && (!res.valid || out_free);
  assign in_ready_o = !s1_valid_q || step;

  tfp_decoder u_decoder (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .byte_i (s1_byte_q),
    .res_o  (res)
  );

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_valid_i && in_ready_o) begin
      s1_valid_d = 1'b1;
    end else if (step) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (step && res.valid) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_byte_q <= in_byte_i;
    end
    if (step && res.valid) begin
      out_q <= res;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign kind_o          = out_q.kind;
  assign value_o         = out_q.value;
  assign slot_o          = out_q.slot;
  assign analog_count_o  = out_q.analog_count;
  assign digital_count_o = out_q.digital_count;

`ifndef NO_ASSERTIONS
  // A held result must never be overwritten by a new one.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |-> !(step && res.valid))
    else $error("held result overwritten");

  // A waiting byte that is not consumed must be blocked by a held result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !step |-> out_valid_q && !out_ready_i && res.valid)
    else $error("input stage stalled without cause");

  // The input stage refuses a beat only while it holds a stalled byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> s1_valid_q && out_valid_q)
    else $error("input refused without a stall");
`endif

endmodule
`default_nettype wire

// ----- test/tfp_tb_pkg.sv -----
// Frame decoding checker used by the telemetry frame parser testbench.
package tfp_tb_pkg;
  import tfp_pkg::*;

  typedef struct packed {
    kind_e       kind;
    logic [15:0] value;
    logic [7:0]  slot;
    logic [7:0]  analog_count;
    logic [7:0]  digital_count;
  } frame_result_t;

  class frame_checker;
    frame_result_t pending_results[$];
    int unsigned   mismatches;
    int unsigned   decoded_bytes;
    int unsigned   results_seen;
    int unsigned   frames_done;

    // Decoder state, cleared at construction like the block after reset.
    bit            in_frame;
    bit [7:0]      char_pos;
    bit [3:0]      analog_total;
    bit [3:0]      digital_total;
    bit [7:0]      digital_first;
    bit [7:0]      frame_len;
    bit [1:0]      analog_nib;
    bit [2:0]      digital_nib;
    bit [11:0]     analog_acc;
    bit [15:0]     digital_acc;
    bit [7:0]      analog_seen;
    bit [7:0]      digital_seen;

    function automatic bit [7:0] bump(input bit [7:0] v);
      return (v == 8'hFF) ? v : v + 8'd1;
    endfunction

    // Advances the decoder by one byte; returns 1 when the byte yields a result.
    function bit decode_byte(input logic [7:0] c, output frame_result_t r);
      logic [3:0]  nib;
      logic [3:0]  dig;
      logic [11:0] analog_add;
      logic [15:0] digital_add;
      nib = 4'(c - ChNib);
      dig = 4'(c - ChDig);
      r.kind = KIND_ANALOG;
      r.value = '0;
      r.slot = '0;
      r.analog_count = '0;
      r.digital_count = '0;
      if (c == ChDrop) in_frame = 1'b0;
      if (c == ChStart) begin
        analog_seen = '0;
        digital_seen = '0;
        analog_nib = '0;
        digital_nib = '0;
        char_pos = 8'd1;
        in_frame = 1'b1;
        return 1'b0;
      end
      if (!in_frame) return 1'b0;
      if (c == ChEnd && char_pos == frame_len) begin
        r.kind = KIND_COMPLETE;
        r.analog_count = analog_seen;
        r.digital_count = digital_seen;
        return 1'b1;
      end
      if (char_pos == 8'd1) begin
        analog_total = dig;
        char_pos = 8'd2;
        return 1'b0;
      end
      if (char_pos == 8'd2) begin
        digital_total = dig;
        char_pos = 8'd3;
        digital_first = 8'(4 * analog_total + 3);
        frame_len = 8'(4 * analog_total + 5 * digital_total + 3);
        return 1'b0;
      end
      char_pos = bump(char_pos);
      // char_pos has already moved on, so compare against the old position.
      if (char_pos - 8'd1 < digital_first || (char_pos == 8'hFF && 8'hFF < digital_first)) begin
        if (c == ChSep) begin
          analog_nib = '0;
          analog_acc = '0;
          return 1'b0;
        end
        if (analog_nib < 2'd3) begin
          analog_add = {8'd0, nib} << (4 * analog_nib);
          analog_acc = analog_acc + analog_add;
        end
        if (analog_nib == 2'd2) begin
          r.kind = KIND_ANALOG;
          r.slot = analog_seen;
          analog_seen = bump(analog_seen);
          analog_nib = 2'd3;
          r.value = {4'd0, analog_acc};
          r.analog_count = analog_seen;
          r.digital_count = digital_seen;
          return 1'b1;
        end
        if (analog_nib < 2'd3) analog_nib++;
        return 1'b0;
      end
      if (c == ChSep) begin
        digital_nib = '0;
        digital_acc = '0;
        return 1'b0;
      end
      if (digital_nib < 3'd4) begin
        digital_add = {12'd0, nib} << (4 * digital_nib);
        digital_acc = digital_acc + digital_add;
      end
      if (digital_nib == 3'd3) begin
        r.kind = KIND_DIGITAL;
        r.slot = digital_seen;
        digital_seen = bump(digital_seen);
        digital_nib = 3'd4;
        r.value = digital_acc;
        r.analog_count = analog_seen;
        r.digital_count = digital_seen;
        return 1'b1;
      end
      if (digital_nib < 3'd4) digital_nib++;
      return 1'b0;
    endfunction

    function void note_byte(input logic [7:0] c);
      frame_result_t r;
      if (in_frame || c == ChStart) decoded_bytes++;
      if (decode_byte(c, r)) pending_results.push_back(r);
    endfunction

    function void check_result(input logic [1:0] kind, input logic [15:0] value,
                               input logic [7:0] slot, input logic [7:0] analog_count,
                               input logic [7:0] digital_count);
      frame_result_t e;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result beat with none pending: kind %0d value %h slot %0d",
                   $realtime, kind, value, slot);
        return;
      end
      e = pending_results.pop_front();
      results_seen++;
      if (e.kind == KIND_COMPLETE) frames_done++;
      if (kind !== e.kind || value !== e.value || slot !== e.slot ||
          analog_count !== e.analog_count || digital_count !== e.digital_count) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"%0t: mismatch: expected kind %0d value %h slot %0d counts %0d/%0d,",
                    " got kind %0d value %h slot %0d counts %0d/%0d"},
                   $realtime, e.kind, e.value, e.slot, e.analog_count, e.digital_count,
                   kind, value, slot, analog_count, digital_count);
      end
    endfunction
  endclass

endpackage

// ----- test/telemetry_frame_parser_core_tb.sv -----
// Self-checking testbench of the telemetry frame parser core.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import tfp_pkg::*;
  import tfp_tb_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [7:0]  in_byte_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [1:0]  kind_o;
  logic [15:0] value_o;
  logic [7:0]  slot_o;
  logic [7:0]  analog_count_o;
  logic [7:0]  digital_count_o;

  frame_checker sb = new;
  bit           no_idle;

  telemetry_frame_parser_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .in_byte_i      (in_byte_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .kind_o         (kind_o),
    .value_o        (value_o),
    .slot_o         (slot_o),
    .analog_count_o (analog_count_o),
    .digital_count_o(digital_count_o)
  );

  always #5 clk_i = ~clk_i;

  // Both beats are sampled here, before any of this edge's drives take effect.
  always @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) sb.note_byte(in_byte_i);
    if (out_valid_o && out_ready_i)
      sb.check_result(kind_o, value_o, slot_o, analog_count_o, digital_count_o);
  end

  function automatic int unsigned draw_wait();
    return no_idle ? 0 : $urandom_range(0, 11);
  endfunction

  function automatic logic [7:0] count_char(input int unsigned n);
    // The character for fifteen would be the drop character, so use one that aliases it.
    return (n == 15) ? ChDig + 8'h1F : ChDig + 8'(n);
  endfunction

  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    gap = draw_wait();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_byte_i  <= b;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // A separator and its nibbles; a rough slot may lose its separator, gain or lose
  // nibbles, or carry arbitrary bytes in nibble positions.
  task automatic send_slot(input int unsigned nibbles, input bit rough);
    int unsigned mode;
    int unsigned n;
    logic [7:0]  b;
    mode = rough ? $urandom_range(0, 3) : 4;
    n = nibbles;
    if (mode == 1) n = nibbles + $urandom_range(1, 2);
    if (mode == 2) n = $urandom_range(0, nibbles - 1);
    if (mode != 0) send_byte(ChSep);
    for (int i = 0; i < n; i++) begin
      if (mode == 3 && $urandom_range(0, 2) == 0) b = 8'($urandom_range(0, 255));
      else b = ChNib + 8'($urandom_range(0, 15));
      send_byte(b);
    end
  endtask

  task automatic send_frame();
    int unsigned flaw;
    int unsigned n_a;
    int unsigned n_d;
    flaw = $urandom_range(0, 9);
    n_a = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 3);
    n_d = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 15) : $urandom_range(0, 3);
    no_idle = ($urandom_range(0, 4) == 0);
    send_byte(ChStart);
    if (flaw == 0) begin
      send_byte(8'($urandom_range(0, 255)));
      send_byte(8'($urandom_range(0, 255)));
    end else begin
      send_byte(count_char(n_a));
      send_byte(count_char(n_d));
    end
    if (flaw == 4) send_byte(ChEnd);
    repeat (n_a) send_slot(3, flaw == 1);
    repeat (n_d) send_slot(4, flaw == 1);
    if (flaw == 2) send_byte(ChDrop);
    send_byte(ChEnd);
    if (flaw == 3) begin
      repeat ($urandom_range(1, 3)) send_slot(4, 1'b0);
      send_byte(ChEnd);
    end
    repeat ($urandom_range(0, 2)) send_byte(8'($urandom_range(0, 255)));
  endtask

  initial begin
    logic [7:0] directed [25];
    directed = '{ChStart, ChDig + 8'd1, ChDig + 8'd1,
                 ChSep, ChNib + 8'd15, ChNib + 8'd15, ChNib + 8'd15,
                 ChSep, ChNib + 8'd15, ChEnd, ChNib, ChNib + 8'd15,
                 ChEnd, ChEnd, ChDrop, 8'h00,
                 ChStart, 8'hFF, 8'h00,
                 ChNib + 8'd1, ChNib + 8'd2, ChNib + 8'd3, ChNib + 8'd4, 8'hFF, ChDrop};
    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    in_byte_i  <= 8'h00;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed[i]) send_byte(directed[i]);

    while (sb.decoded_bytes < 580) send_frame();

    // One long frame drives the frame position into saturation.
    no_idle = 1'b1;
    send_byte(ChStart);
    send_byte(ChDig);
    send_byte(ChDig);
    repeat (60) send_slot(4, 1'b0);
    send_byte(ChEnd);
    no_idle = 1'b0;

    in_valid_i <= 1'b0;
    repeat (2) @(posedge clk_i);
    while (sb.pending_results.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);

    if (sb.pending_results.size() != 0)
      $display("%0d expected results never arrived", sb.pending_results.size());
    $display("Decoded %0d in-frame bytes and checked %0d result beats, %0d of them frame ends.",
             sb.decoded_bytes, sb.results_seen, sb.frames_done);
    $display("Mismatches: %0d", sb.mismatches);
    if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
      $display("[telemetry_frame_parser_core] OK");
    end else begin
      $display("[telemetry_frame_parser_core] ERROR");
    end
    $finish;
  end

  initial begin
    int unsigned gap;
    out_ready_i <= 1'b0;
    @(posedge clk_i iff rst_ni);
    forever begin
      gap = draw_wait();
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  initial begin
    #5_000_000;
    $display("Timed out with %0d results still pending", sb.pending_results.size());
    $display("[telemetry_frame_parser_core] ERROR");
    $finish;
  end

endmodule
